@@ hw/rtl/att_pkg.sv @@
package att_pkg;

   localparam int COLUMNS_DEF    = 80;
   localparam int ROWS_DEF       = 25;
   localparam int MAX_PARAMS_DEF = 4;

   localparam logic [13:0] NUM_LIMIT   = 14'd9999;
   localparam logic [7:0]  ATTR_RESET  = 8'h07;
   localparam int          FIELD_W     = 11;
   localparam int          WORD_W      = 16;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_UP    = 8'h41;
   localparam logic [7:0] CH_DOWN  = 8'h42;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_LEFT  = 8'h44;
   localparam logic [7:0] CH_NEXT  = 8'h45;
   localparam logic [7:0] CH_PREV  = 8'h46;
   localparam logic [7:0] CH_COL   = 8'h47;
   localparam logic [7:0] CH_POS   = 8'h48;
   localparam logic [7:0] CH_ED    = 8'h4A;
   localparam logic [7:0] CH_EL    = 8'h4B;
   localparam logic [7:0] CH_ROW   = 8'h64;
   localparam logic [7:0] CH_POS2  = 8'h66;
   localparam logic [7:0] CH_SGR   = 8'h6D;
   localparam logic [7:0] CH_SAVE  = 8'h73;
   localparam logic [7:0] CH_REST  = 8'h75;

   localparam logic [1:0] PH_TEXT = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CSI  = 2'd2;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_FILL   = 2'd2;
   localparam logic [1:0] CMD_SCROLL = 2'd3;

   localparam logic [2:0] CSR_ATTR = 3'd0;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SGR    = 5'b00100,
      S_OUT0   = 5'b01000,
      S_OUT1   = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic sgr_step;
      logic sel1;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_sgr;
      logic sgr_last;
      logic two;
   } dp_status_type;

endpackage

@@ hw/rtl/ansi_text_terminal_core.sv @@
// each accepted byte is decoded, then takes one sgr step per parameter slot in use
//   (up to MAX_PARAMS) for an sgr sequence, then gives one or two output words
// no new byte is taken until the last word of the previous one is accepted, as the
//   decode controller handles one byte at a time
// reset: synchronous, active high; text mode, cursor home, attribute 7
module ansi_text_terminal_core #(
   parameter int COLUMNS    = att_pkg::COLUMNS_DEF,
   parameter int ROWS       = att_pkg::ROWS_DEF,
   parameter int MAX_PARAMS = att_pkg::MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // command, cell_address, cell_count, cell_word, cursor_out
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]              dflt_attr_ff;
   att_pkg::ctl_cmd_type    cmd;
   att_pkg::dp_status_type  status;
   logic [1:0]              o_command;
   logic [10:0]             o_address, o_count, o_cursor;
   logic [15:0]             o_word;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == att_pkg::CSR_ATTR[0]) ? {24'd0, dflt_attr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_attr_ff <= att_pkg::ATTR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == att_pkg::CSR_ATTR[0]) begin
         dflt_attr_ff <= csr_pwdata[7:0];
      end
   end

   att_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_last   (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   att_datapath #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .in_byte      (req_tdata),
      .default_attr (dflt_attr_ff),
      .cmd          (cmd),
      .status       (status),
      .o_command    (o_command),
      .o_address    (o_address),
      .o_count      (o_count),
      .o_word       (o_word),
      .o_cursor     (o_cursor)
   );

   assign rsp_tdata = {5'd0, o_cursor, o_word, o_count, o_address, o_command};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while a word is pending");

   a_decode_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid && !req_tready)
      else $error("byte not decoded before output");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("final word did not free the input");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[50:40] < 11'(COLUMNS * ROWS)))
      else $error("cursor off screen");

endmodule

@@ hw/rtl/att_ctrl.sv @@
module att_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_last,
   output att_pkg::ctl_cmd_type   cmd,
   input  att_pkg::dp_status_type status
);

   att_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= att_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rsp_last     = 1'b0;
      unique case (state_ff)
         att_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) state_in = att_pkg::S_DECODE;
         end
         att_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = status.is_sgr ? att_pkg::S_SGR : att_pkg::S_OUT0;
         end
         att_pkg::S_SGR: begin
            cmd.sgr_step = 1'b1;
            if (status.sgr_last) state_in = att_pkg::S_OUT0;
         end
         att_pkg::S_OUT0: begin
            rsp_tvalid = 1'b1;
            rsp_last   = !status.two;
            if (rsp_tready) state_in = status.two ? att_pkg::S_OUT1 : att_pkg::S_IDLE;
         end
         att_pkg::S_OUT1: begin
            rsp_tvalid = 1'b1;
            rsp_last   = 1'b1;
            cmd.sel1   = 1'b1;
            if (rsp_tready) state_in = att_pkg::S_IDLE;
         end
         default: state_in = att_pkg::S_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/att_datapath.sv @@
module att_datapath #(
   parameter int COLUMNS    = att_pkg::COLUMNS_DEF,
   parameter int ROWS       = att_pkg::ROWS_DEF,
   parameter int MAX_PARAMS = att_pkg::MAX_PARAMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    in_byte,
   input  logic [7:0]                    default_attr,
   input  att_pkg::ctl_cmd_type          cmd,
   output att_pkg::dp_status_type        status,
   output logic [1:0]                    o_command,
   output logic [att_pkg::FIELD_W-1:0]   o_address,
   output logic [att_pkg::FIELD_W-1:0]   o_count,
   output logic [att_pkg::WORD_W-1:0]    o_word,
   output logic [att_pkg::FIELD_W-1:0]   o_cursor
);

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int PW    = $clog2(MAX_PARAMS);
   localparam int CELLS = COLUMNS * ROWS;
   localparam int LW    = $clog2(CELLS + 1);
   localparam int FW    = att_pkg::FIELD_W;

   logic [7:0]    byte_ff;
   logic [1:0]    phase_ff, phase_in;
   logic [13:0]   acc_ff, acc_in;
   logic [13:0]   par_ff [MAX_PARAMS];
   logic [PW-1:0] slot_ff, slot_in, idx_ff;
   logic [RW-1:0] row_ff, row_in, srow_ff;
   logic [CW-1:0] col_ff, col_in, scol_ff;
   logic [7:0]    attr_ff;
   logic          save_en, par_store, par_clear;

   logic [1:0]    r0_cmd_ff, r0_cmd_in, r1_cmd_ff, r1_cmd_in;
   logic [FW-1:0] r0_addr_ff, r0_addr_in, r1_addr_ff, r1_addr_in;
   logic [FW-1:0] r0_cnt_ff, r0_cnt_in, r1_cnt_ff, r1_cnt_in;
   logic [15:0]   r0_word_ff, r0_word_in, r1_word_ff, r1_word_in;
   logic          two_ff, two_in;

   logic [LW-1:0] lin, row_base;
   logic [15:0]   blank;

   // text path
   logic [RW:0]   t_row;
   logic [CW:0]   t_col, tab_delta;
   logic          t_write, t_scroll;

   // csi final path
   logic [13:0]        p0, p1;
   logic signed [15:0] sx, sy, sn, tx, ty, cx, cy;
   logic               is_digit, do_text, do_place, sgr_hit;
   logic [17:0]        acc_mul;

   function automatic logic signed [15:0] clamp(input logic signed [15:0] v,
                                                input logic signed [15:0] hi);
      logic signed [15:0] r;
      r = v;
      if (v < 0) r = 16'sd0;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [7:0] sgr(input logic [7:0] a, input logic [7:0] d,
                                      input logic [13:0] code);
      logic [3:0]  fg, bg;
      logic [13:0] off;
      logic [7:0]  r;
      fg = a[3:0];
      bg = a[7:4];
      r  = a;
      if (code == 14'd0) r = d;
      else if (code == 14'd1) r = {bg, fg | 4'h8};
      else if (code == 14'd22) r = {bg, fg & 4'h7};
      else if (code >= 14'd30 && code <= 14'd37) begin
         off = code - 14'd30;
         r   = {bg, fg[3], off[2:0]};
      end else if (code == 14'd39) r = {bg, 4'h7};
      else if (code >= 14'd40 && code <= 14'd47) begin
         off = code - 14'd40;
         r   = {1'b0, off[2:0], fg};
      end else if (code == 14'd49) r = {4'h0, fg};
      else if (code >= 14'd90 && code <= 14'd97) begin
         off = code - 14'd90;
         r   = {bg, 1'b1, off[2:0]};
      end else if (code >= 14'd100 && code <= 14'd107) begin
         off = code - 14'd100;
         r   = {1'b1, off[2:0], fg};
      end
      return r;
   endfunction

   assign row_base = LW'(row_ff) * LW'(COLUMNS);
   assign lin      = row_base + LW'(col_ff);
   assign blank    = {attr_ff, att_pkg::CH_SPACE};

   // ordinary bytes: cursor motion, write and wrap into a scroll
   always_comb begin
      t_row     = {1'b0, row_ff};
      t_col     = {1'b0, col_ff};
      t_write   = 1'b0;
      tab_delta = (CW+1)'(4'd8 - {1'b0, lin[2:0]});
      case (byte_ff)
         att_pkg::CH_LF: begin
            t_row = {1'b0, row_ff} + 1'b1;
            t_col = '0;
         end
         att_pkg::CH_CR: t_col = '0;
         att_pkg::CH_TAB: begin
            t_col = {1'b0, col_ff} + tab_delta;
            if (t_col >= (CW+1)'(COLUMNS)) begin
               t_col = t_col - (CW+1)'(COLUMNS);
               t_row = {1'b0, row_ff} + 1'b1;
            end
         end
         att_pkg::CH_BS: begin
            if (col_ff != '0) t_col = {1'b0, col_ff} - 1'b1;
            else if (row_ff != '0) begin
               t_row = {1'b0, row_ff} - 1'b1;
               t_col = (CW+1)'(COLUMNS - 1);
            end
         end
         default: begin
            if (byte_ff >= att_pkg::CH_SPACE) begin
               t_write = 1'b1;
               t_col   = {1'b0, col_ff} + 1'b1;
               if (t_col == (CW+1)'(COLUMNS)) begin
                  t_col = '0;
                  t_row = {1'b0, row_ff} + 1'b1;
               end
            end
         end
      endcase
      t_scroll = (t_row == (RW+1)'(ROWS));
      if (t_scroll) begin
         t_row = (RW+1)'(ROWS - 1);
         t_col = '0;
      end
   end

   always_comb begin
      p0 = (slot_ff == '0) ? acc_ff : par_ff[0];
      if (slot_ff == '0) p1 = 14'd1;
      else if (slot_ff == PW'(1)) p1 = acc_ff;
      else p1 = par_ff[1];
      sx = 16'(col_ff);
      sy = 16'(row_ff);
      sn = (p0 == 14'd0) ? 16'sd1 : 16'(p0);
   end

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      slot_in    = slot_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      save_en    = 1'b0;
      par_store  = 1'b0;
      par_clear  = 1'b0;
      do_text    = 1'b0;
      do_place   = 1'b0;
      sgr_hit    = 1'b0;
      tx         = sx;
      ty         = sy;
      cx         = '0;
      cy         = '0;
      r0_cmd_in  = att_pkg::CMD_NONE;
      r0_addr_in = '0;
      r0_cnt_in  = '0;
      r0_word_in = '0;
      r1_cmd_in  = att_pkg::CMD_SCROLL;
      r1_addr_in = FW'((ROWS - 1) * COLUMNS);
      r1_cnt_in  = FW'(COLUMNS);
      r1_word_in = blank;
      two_in     = 1'b0;
      is_digit   = byte_ff >= att_pkg::CH_ZERO && byte_ff <= att_pkg::CH_NINE;
      acc_mul    = 18'(acc_ff) * 18'd10 + 18'(byte_ff - att_pkg::CH_ZERO);

      case (phase_ff)
         att_pkg::PH_ESC: begin
            if (byte_ff == att_pkg::CH_LBRK) begin
               phase_in  = att_pkg::PH_CSI;
               acc_in    = '0;
               slot_in   = '0;
               par_clear = 1'b1;
            end else begin
               phase_in = att_pkg::PH_TEXT;
               do_text  = 1'b1;
            end
         end
         att_pkg::PH_CSI: begin
            if (is_digit) begin
               acc_in = (acc_mul > 18'(att_pkg::NUM_LIMIT)) ? att_pkg::NUM_LIMIT
                                                            : acc_mul[13:0];
            end else if (byte_ff == att_pkg::CH_SEMI) begin
               if (slot_ff != PW'(MAX_PARAMS - 1)) begin
                  par_store = 1'b1;
                  slot_in   = slot_ff + 1'b1;
                  acc_in    = '0;
               end
            end else begin
               par_store = 1'b1;
               phase_in  = att_pkg::PH_TEXT;
               case (byte_ff)
                  att_pkg::CH_SGR:   sgr_hit = 1'b1;
                  att_pkg::CH_UP:    begin do_place = 1'b1; ty = sy - sn; end
                  att_pkg::CH_DOWN:  begin do_place = 1'b1; ty = sy + sn; end
                  att_pkg::CH_RIGHT: begin do_place = 1'b1; tx = sx + sn; end
                  att_pkg::CH_LEFT:  begin do_place = 1'b1; tx = sx - sn; end
                  att_pkg::CH_NEXT:  begin do_place = 1'b1; tx = '0; ty = sy + sn; end
                  att_pkg::CH_PREV:  begin do_place = 1'b1; tx = '0; ty = sy - sn; end
                  att_pkg::CH_POS, att_pkg::CH_POS2: begin
                     do_place = 1'b1;
                     tx = 16'(p1) - 16'sd1;
                     ty = 16'(p0) - 16'sd1;
                  end
                  att_pkg::CH_COL:   begin do_place = 1'b1; tx = 16'(p0) - 16'sd1; end
                  att_pkg::CH_ROW:   begin do_place = 1'b1; ty = 16'(p0) - 16'sd1; end
                  att_pkg::CH_SAVE:  save_en = 1'b1;
                  att_pkg::CH_REST: begin
                     row_in = srow_ff;
                     col_in = scol_ff;
                  end
                  att_pkg::CH_ED: begin
                     r0_word_in = blank;
                     if (p0 == 14'd0) begin
                        r0_cmd_in  = att_pkg::CMD_FILL;
                        r0_addr_in = FW'(lin);
                        r0_cnt_in  = FW'(LW'(CELLS) - lin);
                     end else if (p0 == 14'd1) begin
                        r0_cmd_in = att_pkg::CMD_FILL;
                        r0_cnt_in = FW'(lin + 1'b1);
                     end else if (p0 == 14'd2) begin
                        r0_cmd_in = att_pkg::CMD_FILL;
                        r0_cnt_in = FW'(CELLS);
                        row_in    = '0;
                        col_in    = '0;
                     end else begin
                        r0_word_in = '0;
                     end
                  end
                  att_pkg::CH_EL: begin
                     r0_word_in = blank;
                     r0_addr_in = FW'(row_base);
                     if (p0 == 14'd0) begin
                        r0_cmd_in  = att_pkg::CMD_FILL;
                        r0_addr_in = FW'(lin);
                        r0_cnt_in  = FW'((CW+1)'(COLUMNS) - {1'b0, col_ff});
                     end else if (p0 == 14'd1) begin
                        r0_cmd_in = att_pkg::CMD_FILL;
                        r0_cnt_in = FW'({1'b0, col_ff} + 1'b1);
                     end else if (p0 == 14'd2) begin
                        r0_cmd_in = att_pkg::CMD_FILL;
                        r0_cnt_in = FW'(COLUMNS);
                     end else begin
                        r0_word_in = '0;
                        r0_addr_in = '0;
                     end
                  end
                  default: do_text = 1'b1;
               endcase
            end
         end
         default: begin
            phase_in = att_pkg::PH_TEXT;
            if (byte_ff == att_pkg::CH_ESC) phase_in = att_pkg::PH_ESC;
            else do_text = 1'b1;
         end
      endcase

      if (do_place) begin
         cx     = clamp(tx, 16'(COLUMNS - 1));
         cy     = clamp(ty, 16'(ROWS - 1));
         row_in = RW'(cy);
         col_in = CW'(cx);
      end

      if (do_text) begin
         row_in = RW'(t_row);
         col_in = CW'(t_col);
         if (t_write) begin
            r0_cmd_in  = att_pkg::CMD_WRITE;
            r0_addr_in = FW'(lin);
            r0_cnt_in  = FW'(1);
            r0_word_in = {attr_ff, byte_ff};
            two_in     = t_scroll;
         end else if (t_scroll) begin
            r0_cmd_in  = att_pkg::CMD_SCROLL;
            r0_addr_in = FW'((ROWS - 1) * COLUMNS);
            r0_cnt_in  = FW'(COLUMNS);
            r0_word_in = blank;
         end
      end
   end

   assign status.is_sgr   = sgr_hit;
   assign status.sgr_last = (idx_ff == slot_ff);
   assign status.two      = two_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= att_pkg::PH_TEXT;
         acc_ff   <= '0;
         slot_ff  <= '0;
         idx_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         srow_ff  <= '0;
         scol_ff  <= '0;
         attr_ff  <= att_pkg::ATTR_RESET;
         two_ff   <= 1'b0;
         for (int i = 0; i < MAX_PARAMS; i++) par_ff[i] <= '0;
      end else begin
         if (cmd.load) byte_ff <= in_byte;
         if (cmd.decode) begin
            phase_ff   <= phase_in;
            acc_ff     <= acc_in;
            slot_ff    <= slot_in;
            row_ff     <= row_in;
            col_ff     <= col_in;
            idx_ff     <= '0;
            two_ff     <= two_in;
            r0_cmd_ff  <= r0_cmd_in;
            r0_addr_ff <= r0_addr_in;
            r0_cnt_ff  <= r0_cnt_in;
            r0_word_ff <= r0_word_in;
            r1_cmd_ff  <= r1_cmd_in;
            r1_addr_ff <= r1_addr_in;
            r1_cnt_ff  <= r1_cnt_in;
            r1_word_ff <= r1_word_in;
            if (save_en) begin
               srow_ff <= row_ff;
               scol_ff <= col_ff;
            end
            if (par_clear) begin
               for (int i = 0; i < MAX_PARAMS; i++) par_ff[i] <= '0;
            end else if (par_store) begin
               par_ff[slot_ff] <= acc_ff;
            end
         end
         // one sgr code per cycle, slots 0 up to the last one filled
         if (cmd.sgr_step) begin
            attr_ff <= sgr(attr_ff, default_attr, par_ff[idx_ff]);
            idx_ff  <= idx_ff + 1'b1;
         end
      end
   end

   assign o_command = cmd.sel1 ? r1_cmd_ff  : r0_cmd_ff;
   assign o_address = cmd.sel1 ? r1_addr_ff : r0_addr_ff;
   assign o_count   = cmd.sel1 ? r1_cnt_ff  : r0_cnt_ff;
   assign o_word    = cmd.sel1 ? r1_word_ff : r0_word_ff;
   assign o_cursor  = FW'(lin);

endmodule

@@ sim/terminal_checker.sv @@
module terminal_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = att_pkg::COLUMNS_DEF;
   localparam int ROWSN = att_pkg::ROWS_DEF;
   localparam int NPAR  = att_pkg::MAX_PARAMS_DEF;
   localparam int CELLS = COLS * ROWSN;

   typedef struct packed {
      logic [1:0]  command;
      logic [10:0] cell_address;
      logic [10:0] cell_count;
      logic [15:0] cell_word;
      logic [10:0] cursor_out;
      logic        last;
   } screen_word_type;

   screen_word_type screen_q[$];
   screen_word_type step_words[2];
   int              step_n;

   logic [7:0] dflt_attr, attr;
   logic [1:0] phase;
   int         acc, slot, cursor, saved;
   int         params[NPAR];

   function automatic logic [15:0] blank();
      return {attr, att_pkg::CH_SPACE};
   endfunction

   function automatic void push_cmd(logic [1:0] c, int a, int n, logic [15:0] w);
      if (step_n < 2) begin
         step_words[step_n] = '{c, a[10:0], n[10:0], w, 11'd0, 1'b0};
         step_n++;
      end
   endfunction

   function automatic int clip(int v, int hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
   endfunction

   function automatic void move_to(int x, int y);
      cursor = clip(y, ROWSN - 1) * COLS + clip(x, COLS - 1);
   endfunction

   function automatic void sgr(int code);
      logic [3:0] fg, bg;
      fg = attr[3:0];
      bg = attr[7:4];
      if (code == 0) begin
         attr = dflt_attr;
         return;
      end
      if (code == 1) fg[3] = 1'b1;
      else if (code == 22) fg[3] = 1'b0;
      else if (code >= 30 && code <= 37) fg = {fg[3], 3'(code - 30)};
      else if (code == 39) fg = 4'd7;
      else if (code >= 40 && code <= 47) bg = 4'(code - 40);
      else if (code == 49) bg = 4'd0;
      else if (code >= 90 && code <= 97) fg = {1'b1, 3'(code - 90)};
      else if (code >= 100 && code <= 107) bg = {1'b1, 3'(code - 100)};
      else return;
      attr = {bg, fg};
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      int row;
      row = cursor / COLS;
      if (c == att_pkg::CH_LF) cursor = (row + 1) * COLS;
      else if (c == att_pkg::CH_CR) cursor = row * COLS;
      else if (c == att_pkg::CH_TAB) cursor = (cursor + 8) & ~7;
      else if (c == att_pkg::CH_BS) begin
         if (cursor > 0) cursor--;
      end else if (c >= att_pkg::CH_SPACE) begin
         push_cmd(att_pkg::CMD_WRITE, cursor, 1, {attr, c});
         cursor++;
      end
      if (cursor >= CELLS) begin
         cursor = (ROWSN - 1) * COLS;
         push_cmd(att_pkg::CMD_SCROLL, cursor, COLS, blank());
      end
   endfunction

   // returns 0 when the final byte is not a supported command
   function automatic bit sequence_end(logic [7:0] c);
      int x, y, p0, p1, n;
      x = cursor % COLS;
      y = cursor / COLS;
      p0 = params[0];
      p1 = slot >= 1 ? params[1] : 1;
      n = p0 == 0 ? 1 : p0;
      case (c)
         att_pkg::CH_SGR: for (int i = 0; i <= slot && i < NPAR; i++) sgr(params[i]);
         att_pkg::CH_UP:    move_to(x, y - n);
         att_pkg::CH_DOWN:  move_to(x, y + n);
         att_pkg::CH_RIGHT: move_to(x + n, y);
         att_pkg::CH_LEFT:  move_to(x - n, y);
         att_pkg::CH_NEXT:  move_to(0, y + n);
         att_pkg::CH_PREV:  move_to(0, y - n);
         att_pkg::CH_POS, att_pkg::CH_POS2: move_to(p1 - 1, p0 - 1);
         att_pkg::CH_COL:   move_to(p0 - 1, y);
         att_pkg::CH_ROW:   move_to(x, p0 - 1);
         att_pkg::CH_SAVE:  saved = cursor;
         att_pkg::CH_REST:  cursor = saved < CELLS ? saved : CELLS - 1;
         att_pkg::CH_ED: begin
            if (p0 == 0) push_cmd(att_pkg::CMD_FILL, cursor, CELLS - cursor, blank());
            else if (p0 == 1) push_cmd(att_pkg::CMD_FILL, 0, cursor + 1, blank());
            else if (p0 == 2) begin
               push_cmd(att_pkg::CMD_FILL, 0, CELLS, blank());
               cursor = 0;
            end
         end
         att_pkg::CH_EL: begin
            if (p0 == 0) push_cmd(att_pkg::CMD_FILL, cursor, COLS - x, blank());
            else if (p0 == 1) push_cmd(att_pkg::CMD_FILL, y * COLS, x + 1, blank());
            else if (p0 == 2) push_cmd(att_pkg::CMD_FILL, y * COLS, COLS, blank());
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic void predict_byte(logic [7:0] c);
      step_n = 0;
      if (phase == att_pkg::PH_ESC) begin
         if (c == att_pkg::CH_LBRK) begin
            phase = att_pkg::PH_CSI;
            acc = 0;
            slot = 0;
            foreach (params[i]) params[i] = 0;
         end else begin
            phase = att_pkg::PH_TEXT;
            plain_byte(c);
         end
      end else if (phase == att_pkg::PH_CSI) begin
         if (c >= att_pkg::CH_ZERO && c <= att_pkg::CH_NINE) begin
            acc = acc * 10 + (c - att_pkg::CH_ZERO);
            if (acc > att_pkg::NUM_LIMIT) acc = att_pkg::NUM_LIMIT;
         end else if (c == att_pkg::CH_SEMI) begin
            if (slot < NPAR - 1) begin
               params[slot] = acc;
               slot++;
               acc = 0;
            end
         end else begin
            params[slot] = acc;
            phase = att_pkg::PH_TEXT;
            if (!sequence_end(c)) plain_byte(c);
         end
      end else begin
         if (c == att_pkg::CH_ESC) phase = att_pkg::PH_ESC;
         else plain_byte(c);
      end
      if (step_n == 0) push_cmd(att_pkg::CMD_NONE, 0, 0, 16'd0);
      for (int k = 0; k < step_n; k++) begin
         step_words[k].cursor_out = cursor[10:0];
         step_words[k].last = (k == step_n - 1);
         screen_q.push_back(step_words[k]);
      end
   endfunction

   screen_word_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         dflt_attr = att_pkg::ATTR_RESET;
         attr = att_pkg::ATTR_RESET;
         phase = att_pkg::PH_TEXT;
         acc = 0;
         slot = 0;
         cursor = 0;
         saved = 0;
         foreach (params[i]) params[i] = 0;
         screen_q.delete();
         fail_count <= 0;
         pending_words <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite &&
             csr_paddr == {att_pkg::CSR_ATTR[0], 2'b00})
            dflt_attr = csr_pwdata[7:0];
         if (req_tvalid && req_tready) predict_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[1:0], rsp_tdata[12:2], rsp_tdata[23:13], rsp_tdata[39:24],
                    rsp_tdata[50:40], rsp_tlast};
            if (screen_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = screen_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: cmd %0d/%0d addr %0d/%0d cnt %0d/%0d",
                               " word %h/%h cur %0d/%0d last %b/%b"},
                        want.command, got.command, want.cell_address, got.cell_address,
                        want.cell_count, got.cell_count, want.cell_word, got.cell_word,
                        want.cursor_out, got.cursor_out, want.last, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_words <= screen_q.size();
      end
   end

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_words;
   int          cycle_count = 0;
   int          hold_off = 0;
   int          rsp_wait = 0;
   int          draw;
   bit          hold_go = 1'b0;
   bit          hold_done = 1'b0;

   ansi_text_terminal_core u_dut (.*);

   terminal_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall per word, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
         hold_off <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_off <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         draw = $urandom_range(0, 12);
         rsp_tready <= (draw == 0);
         rsp_wait <= draw;
      end else if (!rsp_tready) begin
         if (rsp_wait <= 1) rsp_tready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   task automatic write_attr(logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= {att_pkg::CSR_ATTR[0], 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic send_byte(logic [7:0] b, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0 || !req_tready) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_number();
      int kind;
      kind = $urandom_range(0, 5);
      if (kind == 0) send_text("99999");
      else if (kind == 1) send_text($sformatf("%0d", $urandom_range(0, 120)));
      else if (kind == 2) send_text($sformatf("%0d", $urandom_range(0, 9)));
      else if (kind == 3) send_text($sformatf("%0d", $urandom_range(0, 3)));
   endtask

   task automatic random_burst(int count);
      string finals = "ABCDEFHfGdsuJKmmmxz@";
      int nparm;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               send_byte(att_pkg::CH_ESC); send_byte(att_pkg::CH_LBRK);
               nparm = $urandom_range(0, 6);
               for (int p = 0; p < nparm; p++) begin
                  random_number();
                  if (p != nparm - 1) send_byte(att_pkg::CH_SEMI);
               end
               send_byte(finals[$urandom_range(0, finals.len() - 1)]);
            end
            4, 5: send_byte($urandom_range(32, 126));
            6: send_byte($urandom_range(0, 255));
            7: send_byte($urandom_range(0, 1) ? att_pkg::CH_LF : att_pkg::CH_TAB);
            8: begin
               send_byte(att_pkg::CH_ESC);
               send_byte($urandom_range(0, 255));
            end
            default: send_byte($urandom_range(0, 31));
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: printable, controls, escape corner cases
      send_text("A~"); send_byte(8'hFF); send_byte(8'h00);
      send_byte(att_pkg::CH_CR); send_byte(att_pkg::CH_BS);
      send_byte(att_pkg::CH_TAB); send_byte(att_pkg::CH_BS);
      send_byte(att_pkg::CH_ESC); send_byte(att_pkg::CH_ESC); send_byte("x");
      send_text("\033[1;31;44;99;7m"); send_text("\033[0m");
      send_text("\033[99999;0H"); send_text("\033[0A\033[s\033[0;0f\033[u");
      send_text("\033[3K\033[1K\033[2J\033[1J\033[0J\033[K\033[2K");
      send_text("\033[5E\033[F\033[90G\033[0d\033[2C\033[9D\033[B");
      send_text("\033[25H\n\n\033[z");
      drain();

      write_attr(8'hFF); send_text("\033[0mQ\033[25;80H#");
      drain();
      write_attr(8'h00); send_text("\033[m\033[97;107mZ");
      drain();

      // long receiver hold-off while bytes keep coming
      hold_go <= 1'b1;
      send_text("ABCDEFGHIJKL\033[2J\033[31mXYZ");
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_attr(phase == 3 ? 8'h07 : 8'($urandom_range(0, 255)));
         random_burst(55);
         drain();
      end

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/att_pkg.sv
hw/rtl/att_ctrl.sv
hw/rtl/att_datapath.sv
hw/rtl/ansi_text_terminal_core.sv
sim/terminal_checker.sv
sim/testbench.sv
